// File: rtl/sudiv_pkg.sv
// sudiv_pkg: shared constants, mode codes, controller states and command struct of the divider
`timescale 1ns / 1ps
`default_nettype none
package sudiv_pkg;

	localparam int FIELD_W    = 64;
	localparam int DATA_WIDTH = 64;
	localparam int CNT_W      = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_WIDTH - 1);

	typedef enum logic [1:0] {
		MODE_UQUOT = 2'd0,
		MODE_UREM  = 2'd1,
		MODE_SQUOT = 2'd2,
		MODE_SREM  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_ITER,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic prep;
		logic step;
		logic finish;
	} cmd_t;

endpackage
`default_nettype wire

// File: rtl/sudiv_ctrl.sv
// sudiv_ctrl: sequencing state machine and iteration counter of the divider
`timescale 1ns / 1ps
`default_nettype none
module sudiv_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output sudiv_pkg::cmd_t    cmd,
	output logic               busy,
	output logic               done
);
	import sudiv_pkg::*;

	state_t            state_q;
	state_t            state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_FINISH);
			if (state_q == ST_ITER) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP:   state_d = ST_ITER;
			ST_ITER: begin
				if (cnt_q == LAST_STEP) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_PREP:   cmd.prep   = 1'b1;
			ST_ITER:   cmd.step   = 1'b1;
			ST_FINISH: cmd.finish = 1'b1;
			default:   busy       = 1'b1;
		endcase
	end

	assign done = done_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_load_prep: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_PREP))
		else $error("accepted request did not enter prep");

	a_iter_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ITER && cnt_q == LAST_STEP) |=> (state_q == ST_FINISH))
		else $error("iteration count overran");

	a_prep_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PREP) |-> (cnt_q == '0))
		else $error("counter not cleared before iterations");

endmodule
`default_nettype wire

// File: rtl/sudiv_dp.sv
// sudiv_dp: operand registers, restoring shift-subtract step and sign fix-up of the divider
`timescale 1ns / 1ps
`default_nettype none
module sudiv_dp (
	input  wire logic                           clk,
	input  wire sudiv_pkg::cmd_t                cmd,
	input  wire logic [1:0]                     mode,
	input  wire logic [sudiv_pkg::FIELD_W-1:0]  dividend,
	input  wire logic [sudiv_pkg::FIELD_W-1:0]  divisor,
	output logic      [sudiv_pkg::FIELD_W-1:0]  result
);
	import sudiv_pkg::*;

	localparam int DW = DATA_WIDTH;

	logic [1:0]    mode_q;
	logic [DW-1:0] a_q;
	logic [DW-1:0] b_q;
	logic [DW-1:0] quot_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] div_q;
	logic [DW-1:0] res_q;

	logic          is_signed;
	logic [DW-1:0] mag_a;
	logic [DW-1:0] mag_b;
	logic [DW:0]   rem_shift;
	logic [DW:0]   diff;
	logic [DW-1:0] res_d;

	assign is_signed = (mode_q == MODE_SQUOT) || (mode_q == MODE_SREM);
	assign mag_a     = (is_signed && a_q[DW-1]) ? (~a_q + 1'b1) : a_q;
	assign mag_b     = (is_signed && b_q[DW-1]) ? (~b_q + 1'b1) : b_q;

	// partial remainder stays below the divisor, so DW bits plus the shifted-in bit suffice
	assign rem_shift = {rem_q, quot_q[DW-1]};
	assign diff      = rem_shift - {1'b0, div_q};

	always_comb begin
		res_d = '0;
		if (div_q != '0) begin
			case (mode_q)
				MODE_UQUOT: res_d = quot_q;
				MODE_UREM:  res_d = rem_q;
				MODE_SQUOT: res_d = (a_q[DW-1] ^ b_q[DW-1]) ? (~quot_q + 1'b1) : quot_q;
				MODE_SREM:  res_d = a_q[DW-1] ? (~rem_q + 1'b1) : rem_q;
				default:    res_d = '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			a_q    <= dividend[DW-1:0];
			b_q    <= divisor[DW-1:0];
		end
		if (cmd.prep) begin
			quot_q <= mag_a;
			div_q  <= mag_b;
			rem_q  <= '0;
		end
		if (cmd.step) begin
			// borrow clear means the divisor fits: keep the difference, shift in a one
			if (!diff[DW]) begin
				rem_q  <= diff[DW-1:0];
				quot_q <= {quot_q[DW-2:0], 1'b1};
			end else begin
				rem_q  <= rem_shift[DW-1:0];
				quot_q <= {quot_q[DW-2:0], 1'b0};
			end
		end
		if (cmd.finish) begin
			res_q <= res_d;
		end
	end

	assign result = FIELD_W'(res_q);

endmodule
`default_nettype wire

// File: rtl/signed_unsigned_divider_64.sv
// signed_unsigned_divider_64: top level joining the divider controller and datapath
// prep state, DATA_WIDTH shift-subtract steps, sign fix-up state, then the result strobe
// requests are taken only in idle, set by the single iterative subtract unit
// the receiver cannot stall; done is high for exactly one cycle with result
// arst_n clears the controller to idle; operand and result registers are not reset
`timescale 1ns / 1ps
`default_nettype none
module signed_unsigned_divider_64 (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [1:0]                     mode,
	input  wire logic [sudiv_pkg::FIELD_W-1:0]  dividend,
	input  wire logic [sudiv_pkg::FIELD_W-1:0]  divisor,
	output logic                                done,
	output logic      [sudiv_pkg::FIELD_W-1:0]  result
);
	import sudiv_pkg::*;

	cmd_t cmd;

	sudiv_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	sudiv_dp u_dp (
		.clk      (clk),
		.cmd      (cmd),
		.mode     (mode),
		.dividend (dividend),
		.divisor  (divisor),
		.result   (result)
	);

endmodule
`default_nettype wire
